[rtl/assert_macros.svh]
// Assertion macros used by the port-level checker.
// Plain text macros only; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted (active low)
`define ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted (active low)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/tbkt_pkg.sv]
// Package for the keyed/tint tile blitter: constants, payload structs,
// register indexes and controller-datapath command types. No dependencies.
package tbkt_pkg;

    localparam int MAX_SCALE    = 16;
    localparam int ADDRESS_BITS = 24;

    localparam int TILE_MAX   = 64;
    localparam int MAP_MAX    = 256;
    localparam int TILE_IDX_W = 16;
    localparam int SC_W       = $clog2(MAX_SCALE + 1);

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // register indexes (paddr[4:2])
    localparam logic [2:0] REG_SCALE     = 3'd0;
    localparam logic [2:0] REG_TILE_W    = 3'd1;
    localparam logic [2:0] REG_TILE_H    = 3'd2;
    localparam logic [2:0] REG_MAP_W     = 3'd3;
    localparam logic [2:0] REG_TINT      = 3'd4;

    typedef struct packed {
        logic        mode;
        logic [15:0] tile_index;
        logic [31:0] pixel_value;
    } in_item_t;

    typedef struct packed {
        logic [23:0] address;
        logic [31:0] write_pixel;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [4:0]  scale;
        logic [6:0]  tile_width;
        logic [6:0]  tile_height;
        logic [8:0]  map_width_tiles;
        logic [23:0] tint_color;
    } cfg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV,
        OP_FBW,
        OP_STRIDE,
        OP_BAND,
        OP_ROWOFF,
        OP_BANDOFF,
        OP_TCOL,
        OP_TCOLSC,
        OP_EMIT,
        OP_ADV
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic opaque;
        logic last_loaded;
    } status_t;

endpackage

[rtl/tbkt_regs.sv]
// APB-style configuration registers for the tile blitter.
// Depends on tbkt_pkg.
module tbkt_regs
    import tbkt_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] idx;

    assign idx    = paddr[4:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite) begin
            case (idx)
                REG_SCALE:  cfg_next.scale           = pwdata[4:0];
                REG_TILE_W: cfg_next.tile_width      = pwdata[6:0];
                REG_TILE_H: cfg_next.tile_height     = pwdata[6:0];
                REG_MAP_W:  cfg_next.map_width_tiles = pwdata[8:0];
                REG_TINT:   cfg_next.tint_color      = pwdata[23:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_SCALE:  prdata = {27'd0, cfg_reg.scale};
            REG_TILE_W: prdata = {25'd0, cfg_reg.tile_width};
            REG_TILE_H: prdata = {25'd0, cfg_reg.tile_height};
            REG_MAP_W:  prdata = {23'd0, cfg_reg.map_width_tiles};
            REG_TINT:   prdata = {8'd0, cfg_reg.tint_color};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.scale           <= 5'd1;
            cfg_reg.tile_width      <= 7'd16;
            cfg_reg.tile_height     <= 7'd16;
            cfg_reg.map_width_tiles <= 9'd16;
            cfg_reg.tint_color      <= 24'h555555;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/tbkt_ctrl.sv]
// Sequencer for the tile blitter: walks one item through divide, address
// multiply steps, write burst and counter advance. Depends on tbkt_pkg.
module tbkt_ctrl
    import tbkt_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam int DIV_CNT_W = $clog2(TILE_IDX_W);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_FBW,
        S_STRIDE,
        S_BAND,
        S_ROWOFF,
        S_BANDOFF,
        S_TCOL,
        S_TCOLSC,
        S_EMIT,
        S_ADV
    } state_t;

    state_t               state_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        case (state_reg)
            S_IDLE:    cmd.op = s_valid ? OP_LOAD : OP_NONE;
            S_DIV:     cmd.op = OP_DIV;
            S_FBW:     cmd.op = OP_FBW;
            S_STRIDE:  cmd.op = OP_STRIDE;
            S_BAND:    cmd.op = OP_BAND;
            S_ROWOFF:  cmd.op = OP_ROWOFF;
            S_BANDOFF: cmd.op = OP_BANDOFF;
            S_TCOL:    cmd.op = OP_TCOL;
            S_TCOLSC:  cmd.op = OP_TCOLSC;
            S_EMIT:    cmd.op = OP_EMIT;
            S_ADV:     cmd.op = OP_ADV;
            default:   cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            div_cnt_reg <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    div_cnt_reg <= '0;
                    if (s_valid) state_reg <= S_DIV;
                end
                S_DIV: begin
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == DIV_CNT_W'(TILE_IDX_W - 1)) state_reg <= S_FBW;
                end
                S_FBW:     state_reg <= S_STRIDE;
                S_STRIDE:  state_reg <= S_BAND;
                S_BAND:    state_reg <= S_ROWOFF;
                S_ROWOFF:  state_reg <= S_BANDOFF;
                S_BANDOFF: state_reg <= S_TCOL;
                S_TCOL:    state_reg <= S_TCOLSC;
                S_TCOLSC:  state_reg <= status.opaque ? S_EMIT : S_ADV;
                S_EMIT: begin
                    if (status.last_loaded) state_reg <= S_ADV;
                end
                S_ADV:     state_reg <= S_IDLE;
                default:   state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

[rtl/tbkt_dp.sv]
// Datapath for the tile blitter: restoring divider, shared multiplier,
// address accumulator, tile counters and output register. Depends on tbkt_pkg.
module tbkt_dp
    import tbkt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  cmd_t      cmd,
    output status_t   status,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int AW = ADDRESS_BITS;

    // clamped configuration, captured per item
    logic [SC_W-1:0]       sc_reg;
    logic [6:0]            tw_reg;
    logic [6:0]            th_reg;
    logic [8:0]            mw_reg;

    logic [31:0]           value_reg;
    logic                  opaque_reg;

    logic [TILE_IDX_W-1:0] quot_reg;
    logic [7:0]            rem_reg;

    logic [AW-1:0]         fbw_reg;
    logic [AW-1:0]         stride_reg;
    logic [AW-1:0]         band_reg;
    logic [AW-1:0]         tmp_reg;
    logic [AW-1:0]         acc_reg;

    logic [5:0]            col_reg;
    logic [5:0]            row_reg;
    logic [SC_W-1:0]       k_reg;

    logic                  out_valid_reg;
    out_item_t             out_reg;

    logic [AW-1:0]         mul_a;
    logic [AW-1:0]         mul_b;
    logic [2*AW-1:0]       mul_full;
    logic [AW-1:0]         mul_lo;

    logic [8:0]            div_sh;
    logic                  div_ge;

    logic [SC_W-1:0]       sc_clamp;
    logic [6:0]            tw_clamp;
    logic [6:0]            th_clamp;
    logic [8:0]            mw_clamp;
    logic [23:0]           blend;

    logic                  emit_load;
    logic                  emit_last;
    logic [6:0]            col_inc;
    logic [6:0]            row_inc;

    // per-channel average with the tint color, top byte cleared
    function automatic logic [23:0] tint_avg(input logic [23:0] v, input logic [23:0] c);
        logic [8:0] r;
        logic [8:0] g;
        logic [8:0] b;
        r = {1'b0, v[23:16]} + {1'b0, c[23:16]};
        g = {1'b0, v[15:8]} + {1'b0, c[15:8]};
        b = {1'b0, v[7:0]} + {1'b0, c[7:0]};
        return {r[8:1], g[8:1], b[8:1]};
    endfunction

    always_comb begin
        if (cfg.scale == 5'd0)                         sc_clamp = SC_W'(1);
        else if ({27'd0, cfg.scale} > 32'(MAX_SCALE))  sc_clamp = SC_W'(MAX_SCALE);
        else                                           sc_clamp = SC_W'(cfg.scale);

        if (cfg.tile_width == 7'd0)                    tw_clamp = 7'd1;
        else if (cfg.tile_width > 7'(TILE_MAX))        tw_clamp = 7'(TILE_MAX);
        else                                           tw_clamp = cfg.tile_width;

        if (cfg.tile_height == 7'd0)                   th_clamp = 7'd1;
        else if (cfg.tile_height > 7'(TILE_MAX))       th_clamp = 7'(TILE_MAX);
        else                                           th_clamp = cfg.tile_height;

        if (cfg.map_width_tiles == 9'd0)               mw_clamp = 9'd1;
        else if (cfg.map_width_tiles > 9'(MAP_MAX))    mw_clamp = 9'(MAP_MAX);
        else                                           mw_clamp = cfg.map_width_tiles;
    end

    assign blend = tint_avg(s_data.pixel_value[23:0], cfg.tint_color);

    // one restoring divide step per cycle
    assign div_sh = {rem_reg, quot_reg[TILE_IDX_W-1]};
    assign div_ge = (div_sh >= mw_reg);

    // shared multiplier, operands picked by the current step
    always_comb begin
        case (cmd.op)
            OP_FBW: begin
                mul_a = AW'(mw_reg);
                mul_b = AW'(tw_reg);
            end
            OP_STRIDE: begin
                mul_a = fbw_reg;
                mul_b = AW'(sc_reg);
            end
            OP_BAND: begin
                mul_a = stride_reg;
                mul_b = AW'(th_reg);
            end
            OP_ROWOFF: begin
                mul_a = AW'(row_reg);
                mul_b = stride_reg;
            end
            OP_BANDOFF: begin
                mul_a = AW'(quot_reg);
                mul_b = band_reg;
            end
            OP_TCOL: begin
                mul_a = AW'(rem_reg);
                mul_b = AW'(tw_reg);
            end
            OP_TCOLSC: begin
                mul_a = tmp_reg;
                mul_b = AW'(sc_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;
    assign mul_lo   = mul_full[AW-1:0];

    assign emit_load = (cmd.op == OP_EMIT) && (!out_valid_reg || m_ready);
    assign emit_last = (k_reg == sc_reg - 1'b1);

    assign col_inc = {1'b0, col_reg} + 7'd1;
    assign row_inc = {1'b0, row_reg} + 7'd1;

    assign status.opaque      = opaque_reg;
    assign status.last_loaded = emit_load && emit_last;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
        end else begin
            if (emit_load)    out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;

            if (cmd.op == OP_ADV) begin
                if (col_inc >= tw_reg) begin
                    col_reg <= '0;
                    if (row_inc >= th_reg) row_reg <= '0;
                    else                   row_reg <= row_inc[5:0];
                end else begin
                    col_reg <= col_inc[5:0];
                end
            end
        end
    end

    // payload and working registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                sc_reg     <= sc_clamp;
                tw_reg     <= tw_clamp;
                th_reg     <= th_clamp;
                mw_reg     <= mw_clamp;
                quot_reg   <= s_data.tile_index;
                rem_reg    <= '0;
                k_reg      <= '0;
                value_reg  <= s_data.mode ? {8'd0, blend} : s_data.pixel_value;
                opaque_reg <= s_data.mode || (s_data.pixel_value[31:24] != 8'd0);
            end
            OP_DIV: begin
                quot_reg <= {quot_reg[TILE_IDX_W-2:0], div_ge};
                rem_reg  <= div_ge ? 8'(div_sh - mw_reg) : div_sh[7:0];
            end
            OP_FBW:     fbw_reg    <= mul_lo;
            OP_STRIDE:  stride_reg <= mul_lo;
            OP_BAND:    band_reg   <= mul_lo;
            OP_ROWOFF:  acc_reg    <= mul_lo;
            OP_BANDOFF: acc_reg    <= acc_reg + mul_lo;
            OP_TCOL:    tmp_reg    <= mul_lo + AW'(col_reg);
            OP_TCOLSC:  acc_reg    <= acc_reg + mul_lo;
            OP_EMIT: begin
                if (emit_load) begin
                    out_reg.address     <= 24'(acc_reg + AW'(k_reg));
                    out_reg.write_pixel <= value_reg;
                    out_reg.last        <= emit_last;
                    k_reg               <= k_reg + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

[rtl/tile_blit_keyed_tint.sv]
// Top level of the keyed/tint tile blitter: config registers, sequencer
// and datapath. Depends on tbkt_pkg, tbkt_regs, tbkt_ctrl, tbkt_dp.
//
//  channel   dir  handshake               payload
//  s_        in   s_valid / s_ready       in_item_t  {mode, tile_index, pixel_value}
//  m_        out  m_valid / m_ready       out_item_t {address, write_pixel, last}
//  apb       in   psel, penable, pwrite   paddr[4:2] = register index, pwdata / prdata
//
// One item at a time: accept, the bit-serial tile/map divide, the address
// steps on the shared multiplier, then scale write transfers (one per
// cycle unless m_ready stalls) and one counter update. A transparent copy
// skips the write transfers. Reset (aresetn low, synchronous) restores
// register defaults, zeroes the column/row counters and drops m_valid.
// m_ready low holds the output register and the burst; for an item that
// writes, s_ready rises again only after the last transfer has been
// loaded into the output register.
module tile_blit_keyed_tint
    import tbkt_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  in_item_t           s_data,

    output logic               m_valid,
    input  logic               m_ready,
    output out_item_t          m_data,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    // register file; the user must write it only while no item is in flight, nothing in the block enforces this
    tbkt_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // step sequencer; owns s_ready
    tbkt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // arithmetic, counters and the output register
    tbkt_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .cmd     (cmd),
        .status  (status),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

[rtl/tbkt_checker.sv]
// Port-level checks for the tile blitter, bound to the top level.
// Depends on tbkt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tbkt_checker
    import tbkt_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "stalled output changed")

    `ASSERT_NEXT(a_one_item, aclk, aresetn, s_valid && s_ready, !s_ready, "second item accepted while busy")

    `ASSERT_NEXT(a_burst_gapless, aclk, aresetn, m_valid && m_ready && !m_data.last, m_valid, "gap inside a write burst")

    `ASSERT_NEXT(a_burst_addr, aclk, aresetn, m_valid && m_ready && !m_data.last, m_data.address == 24'($past(m_data.address) + 24'd1), "burst address not consecutive")

    `ASSERT_SAME(a_busy_in_burst, aclk, aresetn, m_valid && !m_data.last, !s_ready, "input ready during a burst")

endmodule

bind tile_blit_keyed_tint tbkt_checker u_tbkt_checker (.*);

[sim/tile_blit_keyed_tint_test.sv]
`timescale 1ns / 100ps
// Self-checking bench for the keyed/tint tile blitter: pixel transfers in,
// framebuffer write transfers out, register setup over APB.
// Depends on tbkt_pkg and tile_blit_keyed_tint only.
module tile_blit_keyed_tint_test;
    import tbkt_pkg::*;

    localparam logic MODE_COPY = 1'b0;
    localparam logic MODE_TINT = 1'b1;

    // addresses past the last register; writes there must not land anywhere
    localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [2:0] REG_SPARE_LAST  = 3'd7;

    localparam int ITEMS_PER_PHASE = 29;
    localparam int RANDOM_PHASES   = 8;
    localparam int SETTLE_CYCLES   = 64;      // lets a transparent item still in flight finish
    localparam int DRAIN_LIMIT     = 20000;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int REPORT_MAX      = 10;

    typedef enum logic [1:0] {
        ROW_PREDICT,    // expected writes come from the predictor
        ROW_NO_WRITE,   // typed in: transparent, nothing written
        ROW_ONE_WRITE   // typed in: exactly one write (scale of 1)
    } row_kind_t;

    typedef struct packed {
        in_item_t  item;
        row_kind_t kind;
        out_item_t fixed;
    } blit_row_t;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    in_item_t           s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    out_item_t          m_data;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // predictor's copy of the registers and the column/row counters
    logic [4:0]  cur_scale  = 5'd1;
    logic [6:0]  cur_tile_w = 7'd16;
    logic [6:0]  cur_tile_h = 7'd16;
    logic [8:0]  cur_map_w  = 9'd16;
    logic [23:0] cur_tint   = 24'h555555;
    logic [5:0]  tile_col   = '0;
    logic [5:0]  tile_row   = '0;

    out_item_t pending_writes[$];   // framebuffer writes still owed by the block
    blit_row_t directed_rows[$];

    int  mismatches  = 0;
    int  cycle_count = 0;
    int  stall_left  = 0;
    bit  steady      = 1'b0;        // phase with no gaps on either side

    tile_blit_keyed_tint u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 aclk = ~aclk;

    // hard stop in case the block hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tile_blit_keyed_tint_test: errors");
            $finish;
        end
    end

    task automatic report(input string what);
        mismatches++;
        if (mismatches <= REPORT_MAX) $display("%0t: %s", $time, what);
    endtask

    // mostly back-to-back, sometimes a short gap, rarely a long hold-off
    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic longint unsigned clamp_to(input longint unsigned v,
                                                 input longint unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Expected writes for one accepted pixel, then the column/row advance.
    // With keep cleared only the counters move (rows with typed-in results).
    task automatic predict_writes(input in_item_t it, input bit keep);
        longint unsigned sc, tw, th, mw, fbw, tile, base, addr_full, k;
        logic [8:0]      sum_r, sum_g, sum_b;
        logic [31:0]     value;
        bit              opaque;
        out_item_t       w;
        sc   = clamp_to(cur_scale, MAX_SCALE);
        tw   = clamp_to(cur_tile_w, TILE_MAX);
        th   = clamp_to(cur_tile_h, TILE_MAX);
        mw   = clamp_to(cur_map_w, MAP_MAX);
        fbw  = mw * tw;
        tile = it.tile_index;
        base = (tile / mw) * (fbw * sc * th) + (tile % mw) * tw * sc
             + tile_row * fbw * sc + tile_col * sc;
        if (it.mode == MODE_COPY) begin
            opaque = (it.pixel_value[31:24] != 8'h00);
            value  = it.pixel_value;
        end else begin
            // per-channel average with the tint, alpha byte cleared
            opaque = 1'b1;
            sum_r  = {1'b0, it.pixel_value[23:16]} + {1'b0, cur_tint[23:16]};
            sum_g  = {1'b0, it.pixel_value[15:8]} + {1'b0, cur_tint[15:8]};
            sum_b  = {1'b0, it.pixel_value[7:0]} + {1'b0, cur_tint[7:0]};
            value  = {8'h00, sum_r[8:1], sum_g[8:1], sum_b[8:1]};
        end
        if (keep && opaque) begin
            for (k = 0; k < sc; k++) begin
                addr_full     = base + k;
                w.address     = addr_full[23:0];
                w.write_pixel = value;
                w.last        = (k + 1 == sc);
                pending_writes.push_back(w);
            end
        end
        // counters beyond a shrunken tile wrap here as well
        if (tile_col + 1 >= tw) begin
            tile_col = '0;
            if (tile_row + 1 >= th) tile_row = '0;
            else tile_row = tile_row + 1'b1;
        end else begin
            tile_col = tile_col + 1'b1;
        end
    endtask

    // one APB write: setup, access, then idle before the next one
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SCALE:  cur_scale  = val[4:0];
            REG_TILE_W: cur_tile_w = val[6:0];
            REG_TILE_H: cur_tile_h = val[6:0];
            REG_MAP_W:  cur_map_w  = val[8:0];
            REG_TINT:   cur_tint   = val[23:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic apply_setting(input logic [31:0] sc, input logic [31:0] tw,
                                 input logic [31:0] th, input logic [31:0] mw,
                                 input logic [31:0] tint);
        reg_write(REG_SCALE, sc);
        reg_write(REG_TILE_W, tw);
        reg_write(REG_TILE_H, th);
        reg_write(REG_MAP_W, mw);
        reg_write(REG_TINT, tint);
        reg_write(3'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), $urandom);
    endtask

    // Present one pixel and return at the edge where it transfers. valid only
    // drops when a gap follows, so it is never lowered and raised in one step.
    task automatic push_item(input in_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Idle the input, wait for every owed write, then give a transparent
    // item still in flight time to finish before registers change.
    task automatic finish_phase();
        int waited;
        s_valid <= 1'b0;
        waited = 0;
        while (pending_writes.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (pending_writes.size() != 0) begin
            report($sformatf("%0d expected writes never arrived",
                             pending_writes.size()));
            pending_writes.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic add_row(input logic mode, input logic [15:0] tile,
                           input logic [31:0] pix, input row_kind_t kind,
                           input logic [23:0] addr, input logic [31:0] wpix);
        blit_row_t r;
        r.item.mode        = mode;
        r.item.tile_index  = tile;
        r.item.pixel_value = pix;
        r.kind             = kind;
        r.fixed.address     = addr;
        r.fixed.write_pixel = wpix;
        r.fixed.last        = 1'b1;
        directed_rows.push_back(r);
    endtask

    // Output side: check each write transfer in order, and wiggle m_ready.
    always @(posedge aclk) begin : write_checker
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_writes.size() == 0) begin
                report($sformatf("unexpected write addr %h pixel %h last %b",
                                 m_data.address, m_data.write_pixel, m_data.last));
            end else begin
                want = pending_writes.pop_front();
                if (m_data.address !== want.address ||
                    m_data.write_pixel !== want.write_pixel ||
                    m_data.last !== want.last) begin
                    report($sformatf({"write mismatch: expected addr %h pixel %h last %b,",
                                      " got addr %h pixel %h last %b"},
                                     want.address, want.write_pixel, want.last,
                                     m_data.address, m_data.write_pixel, m_data.last));
                end
            end
        end
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    initial begin : stimulus
        in_item_t    it;
        blit_row_t   r;
        logic [15:0] run_tile;
        int          run_left;
        int          i, p, n;
        run_tile = '0;
        run_left = 0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at reset settings: scale 1, 16x16 tiles, 16-tile map,
        // tint 0x555555. First row of tile 0 covers the opacity corners and
        // tint extremes; tile row 1 then lands one framebuffer row (256) down.
        add_row(MODE_COPY, 16'h0000, 32'hFF000001, ROW_ONE_WRITE, 24'h000000, 32'hFF000001);
        add_row(MODE_COPY, 16'h0000, 32'h00FFFFFF, ROW_NO_WRITE,  24'h000000, 32'h0);
        add_row(MODE_TINT, 16'h0000, 32'hFFFFFFFF, ROW_ONE_WRITE, 24'h000002, 32'h00AAAAAA);
        add_row(MODE_TINT, 16'h0000, 32'h00000000, ROW_ONE_WRITE, 24'h000003, 32'h002A2A2A);
        add_row(MODE_COPY, 16'h0000, 32'h01000000, ROW_ONE_WRITE, 24'h000004, 32'h01000000);
        add_row(MODE_COPY, 16'h0000, 32'hFFFFFFFF, ROW_ONE_WRITE, 24'h000005, 32'hFFFFFFFF);
        add_row(MODE_COPY, 16'h0000, 32'h00000000, ROW_NO_WRITE,  24'h000000, 32'h0);
        for (i = 7; i < 16; i++) begin
            add_row((i % 3 == 0) ? MODE_TINT : MODE_COPY, 16'h0000,
                    (i % 2 == 0) ? 32'hA5C3_5A3C : 32'h5A3C_A5C3, ROW_PREDICT, '0, '0);
        end
        add_row(MODE_COPY, 16'h0000, 32'hFF00FF00, ROW_ONE_WRITE, 24'h000100, 32'hFF00FF00);
        add_row(MODE_COPY, 16'hFFFF, 32'hFFFFFFFF, ROW_PREDICT, '0, '0);
        add_row(MODE_TINT, 16'hFFFF, 32'h5A5A5A5A, ROW_PREDICT, '0, '0);
        add_row(MODE_COPY, 16'h0011, 32'h80123456, ROW_PREDICT, '0, '0);
        add_row(MODE_TINT, 16'h8000, 32'h00FF00FF, ROW_PREDICT, '0, '0);

        foreach (directed_rows[i]) begin
            r = directed_rows[i];
            push_item(r.item);
            if (r.kind == ROW_PREDICT) begin
                predict_writes(r.item, 1'b1);
            end else begin
                predict_writes(r.item, 1'b0);
                if (r.kind == ROW_ONE_WRITE) pending_writes.push_back(r.fixed);
            end
        end
        finish_phase();

        // Random phases. Counters carry across setting changes, so shrinking
        // tiles exercise the wrap of an out-of-range column or row.
        for (p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: apply_setting(16, 64, 64, 256, 32'h00FFFFFF);   // largest legal
                1: apply_setting(1, 1, 1, 1, 32'h00000000);        // smallest legal
                2: apply_setting(0, 0, 0, 0, 32'h00FFFFFF);        // zero acts as one
                3: apply_setting(31, 127, 127, 511, 32'hFFA5A5A5); // clamp from above
                default: apply_setting($urandom_range(1, 16), $urandom_range(1, 8),
                                       $urandom_range(1, 6), $urandom_range(1, 20),
                                       $urandom);
            endcase
            steady = (p % 3 == 1);

            // Mostly runs of pixels from one tile, with stray tile numbers
            // mixed in as noise.
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (run_left == 0) begin
                    if ($urandom_range(0, 1) != 0) run_tile = 16'($urandom_range(0, 63));
                    else run_tile = 16'($urandom);
                    run_left = $urandom_range(1, 12);
                end
                run_left--;
                if ($urandom_range(0, 9) == 0) it.tile_index = 16'($urandom);
                else it.tile_index = run_tile;
                it.mode        = ($urandom_range(0, 9) < 3) ? MODE_TINT : MODE_COPY;
                it.pixel_value = $urandom;
                if ($urandom_range(0, 3) == 0) it.pixel_value[31:24] = 8'h00;
                push_item(it);
                predict_writes(it, 1'b1);
            end
            finish_phase();
        end

        if (mismatches == 0) begin
            $display("tile_blit_keyed_tint_test: clean");
        end else begin
            $display("tile_blit_keyed_tint_test: errors");
        end
        $finish;
    end

endmodule
